// ----- hw/rtl/bq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bq_pkg: shared types, widths and microcode for the biquad filter
// Fixed widths of coefficients, delays and the MAC datapath, the control
// word layout and the sequencer program table.
// ---------------------------------------------------------------------------
package bq_pkg;

    localparam int COEF_WIDTH  = 24;
    localparam int DELAY_WIDTH = 32;
    localparam int PROD_WIDTH  = COEF_WIDTH + DELAY_WIDTH;  // 56
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;            // three products
    localparam int EXT_WIDTH   = ACC_WIDTH + 2;             // room for round + sample
    localparam int CFG_IDX_WIDTH = 3;
    localparam int STEP_WIDTH  = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_A1 = 3'd0,
        CFG_A2 = 3'd1,
        CFG_B0 = 3'd2,
        CFG_B1 = 3'd3,
        CFG_B2 = 3'd4
    } t_cfg_idx;

    // multiplier coefficient operand
    typedef enum logic [2:0] {
        CSEL_A1 = 3'd0,
        CSEL_A2 = 3'd1,
        CSEL_B0 = 3'd2,
        CSEL_B1 = 3'd3,
        CSEL_B2 = 3'd4
    } t_csel;

    // multiplier data operand
    typedef enum logic [1:0] {
        DSEL_D1 = 2'd0,
        DSEL_D2 = 2'd1,
        DSEL_W  = 2'd2
    } t_dsel;

    typedef enum logic [1:0] {
        ACC_NOP  = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    // sequencer flow
    typedef enum logic [1:0] {
        JMP_NEXT    = 2'd0,  // step + 1
        JMP_WAIT_IN = 2'd1,  // hold until a word is taken
        JMP_OUT     = 2'd2   // hold until the output register frees, then restart
    } t_jmp;

    typedef struct packed {
        t_csel   csel;
        t_dsel   dsel;
        logic    mul_en;
        t_acc_op acc_op;
        logic    w_en;    // form inner value from accumulator
        logic    out_en;  // form result, shift delays
        t_jmp    jmp;
    } t_ctrl;

    localparam logic [STEP_WIDTH-1:0] STEP_START = '0;

    // program: w = x + rnd(a1*d1 + a2*d2); y = sat(rnd(b0*w + b1*d1 + b2*d2))
    function automatic t_ctrl ucode(input logic [STEP_WIDTH-1:0] step);
        t_ctrl c;
        c = '{csel: CSEL_A1, dsel: DSEL_D1, mul_en: 1'b0, acc_op: ACC_NOP,
              w_en: 1'b0, out_en: 1'b0, jmp: JMP_NEXT};
        case (step)
            4'd0: begin
                c.jmp = JMP_WAIT_IN;
            end
            4'd1: begin
                c.csel = CSEL_A1; c.dsel = DSEL_D1; c.mul_en = 1'b1;
            end
            4'd2: begin
                c.csel = CSEL_A2; c.dsel = DSEL_D2; c.mul_en = 1'b1;
                c.acc_op = ACC_LOAD;
            end
            4'd3: begin
                c.acc_op = ACC_ADD;
            end
            4'd4: begin
                c.w_en = 1'b1;
            end
            4'd5: begin
                c.csel = CSEL_B0; c.dsel = DSEL_W; c.mul_en = 1'b1;
            end
            4'd6: begin
                c.csel = CSEL_B1; c.dsel = DSEL_D1; c.mul_en = 1'b1;
                c.acc_op = ACC_LOAD;
            end
            4'd7: begin
                c.csel = CSEL_B2; c.dsel = DSEL_D2; c.mul_en = 1'b1;
                c.acc_op = ACC_ADD;
            end
            4'd8: begin
                c.acc_op = ACC_ADD;
            end
            4'd9: begin
                c.out_en = 1'b1;
                c.jmp = JMP_OUT;
            end
            default: begin
                c.jmp = JMP_OUT;  // unused steps fall back to start
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/biquad_direct_form_two_filter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquad_direct_form_two_filter: second-order IIR section, direct form II
// Microcoded MAC sequencer computing one filtered sample per input word.
// ---------------------------------------------------------------------------
// Usage: each input word is one signed sample (Q1.23 at the default width).
// The filter forms w = x + a1*d1 + a2*d2 (feedback is added), then
// y = b0*w + b1*d1 + b2*d2, and shifts the delays (d2 <= d1, d1 <= w).
// Coefficients are Q4.20 and written through the config port while the filter
// is idle; delays hold 32 bits on the sample grid. Each weighted sum is kept
// at full precision and rounded once (half up, ties toward +inf). If w leaves
// the 32-bit delay range it is forced to zero and o_state_flushed is set with
// that result; y saturates to the sample width. The next input word is taken
// only after the previous result has been issued. All five products go
// through a single 24x32 multiplier with a registered product and a wide
// accumulator, stepped by a 10-entry microcode program; the w rounding and
// range check take their own step because y depends on w. A new word is
// accepted while the previous result still sits in the output register; the
// program only waits at its last step if that register is still occupied.
// ---------------------------------------------------------------------------
module biquad_direct_form_two_filter #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write port
    input  logic                                  i_cfg_we,
    input  logic [bq_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  logic [bq_pkg::COEF_WIDTH-1:0]         i_cfg_data,
    // input sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_in_sample,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        o_out_sample,
    output logic                                  o_state_flushed
);

    localparam int EXT_W = bq_pkg::EXT_WIDTH;
    localparam int DLY_W = bq_pkg::DELAY_WIDTH;
    localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(1) <<< (COEF_FRAC_BITS - 1);

    // coefficient registers
    logic signed [bq_pkg::COEF_WIDTH-1:0] r_a1, r_a2, r_b0, r_b1, r_b2;

    // filter state
    logic signed [DLY_W-1:0]        r_d1, r_d2;
    logic signed [DLY_W-1:0]        r_w;
    logic                           r_flush;
    logic signed [SAMPLE_WIDTH-1:0] r_x;

    // sequencer
    logic [bq_pkg::STEP_WIDTH-1:0] r_step, n_step;
    bq_pkg::t_ctrl                 cw;

    // output register
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_flushed;

    logic in_take;
    logic out_free;
    logic out_fire;

    // datapath operands
    logic signed [bq_pkg::COEF_WIDTH-1:0] mul_coef;
    logic signed [DLY_W-1:0]              mul_data;
    logic signed [bq_pkg::ACC_WIDTH-1:0]  acc;

    // rounding and range logic
    logic signed [EXT_W-1:0]   acc_rnd;
    logic signed [EXT_W-1:0]   w_full;
    logic                      w_ovf;
    logic                      y_ovf;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    assign cw         = bq_pkg::ucode(r_step);
    assign o_in_stall = (cw.jmp != bq_pkg::JMP_WAIT_IN);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_fire   = cw.out_en && out_free;

    // step counter with conditional jumps
    always_comb begin
        n_step = r_step;
        case (cw.jmp)
            bq_pkg::JMP_NEXT:    n_step = r_step + 1'b1;
            bq_pkg::JMP_WAIT_IN: n_step = in_take ? r_step + 1'b1 : r_step;
            bq_pkg::JMP_OUT:     n_step = out_free ? bq_pkg::STEP_START : r_step;
            default:             n_step = bq_pkg::STEP_START;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bq_pkg::STEP_START;
        end else begin
            r_step <= n_step;
        end
    end

    // config writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0;
            r_a2 <= '0;
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bq_pkg::CFG_A1: r_a1 <= i_cfg_data;
                bq_pkg::CFG_A2: r_a2 <= i_cfg_data;
                bq_pkg::CFG_B0: r_b0 <= i_cfg_data;
                bq_pkg::CFG_B1: r_b1 <= i_cfg_data;
                bq_pkg::CFG_B2: r_b2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand muxes
    always_comb begin
        case (cw.csel)
            bq_pkg::CSEL_A1: mul_coef = r_a1;
            bq_pkg::CSEL_A2: mul_coef = r_a2;
            bq_pkg::CSEL_B0: mul_coef = r_b0;
            bq_pkg::CSEL_B1: mul_coef = r_b1;
            bq_pkg::CSEL_B2: mul_coef = r_b2;
            default:         mul_coef = '0;
        endcase
        case (cw.dsel)
            bq_pkg::DSEL_D1: mul_data = r_d1;
            bq_pkg::DSEL_D2: mul_data = r_d2;
            bq_pkg::DSEL_W:  mul_data = r_w;
            default:         mul_data = '0;
        endcase
    end

    bq_mac u_mac (
        .i_clk    (i_clk),
        .i_coef   (mul_coef),
        .i_data   (mul_data),
        .i_mul_en (cw.mul_en),
        .i_acc_op (cw.acc_op),
        .o_acc    (acc)
    );

    // round half up, arithmetic shift back to the sample grid
    assign acc_rnd = ($signed({{(EXT_W - bq_pkg::ACC_WIDTH){acc[bq_pkg::ACC_WIDTH-1]}}, acc})
                      + HALF_LSB) >>> COEF_FRAC_BITS;

    // inner value and its 32-bit range check
    assign w_full = acc_rnd + {{(EXT_W - SAMPLE_WIDTH){r_x[SAMPLE_WIDTH-1]}}, r_x};
    assign w_ovf  = (w_full[EXT_W-1:DLY_W-1] != {(EXT_W - DLY_W + 1){w_full[DLY_W-1]}});

    // result saturation
    assign y_ovf = (acc_rnd[EXT_W-1:SAMPLE_WIDTH-1]
                    != {(EXT_W - SAMPLE_WIDTH + 1){acc_rnd[SAMPLE_WIDTH-1]}});
    always_comb begin
        if (!y_ovf) begin
            y_sat = acc_rnd[SAMPLE_WIDTH-1:0];
        end else if (acc_rnd[EXT_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    // sample capture and inner value
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x <= i_in_sample;
        end
        if (cw.w_en) begin
            r_w     <= w_ovf ? '0 : w_full[DLY_W-1:0];
            r_flush <= w_ovf;
        end
    end

    // delays shift when the result is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (out_fire) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_out_sample  <= y_sat;
            r_out_flushed <= r_flush;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_state_flushed = r_out_flushed;

endmodule

// ----- hw/rtl/bq_mac.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bq_mac: registered multiply-accumulate unit
// One 24x32 signed multiplier with a product register, then a wide
// accumulator that loads or adds the registered product.
// ---------------------------------------------------------------------------
module bq_mac (
    input  logic                                    i_clk,
    input  logic signed [bq_pkg::COEF_WIDTH-1:0]    i_coef,
    input  logic signed [bq_pkg::DELAY_WIDTH-1:0]   i_data,
    input  logic                                    i_mul_en,
    input  bq_pkg::t_acc_op                         i_acc_op,
    output logic signed [bq_pkg::ACC_WIDTH-1:0]     o_acc
);

    logic signed [bq_pkg::PROD_WIDTH-1:0] r_prod;
    logic signed [bq_pkg::ACC_WIDTH-1:0]  r_acc;
    logic signed [bq_pkg::ACC_WIDTH-1:0]  prod_ext;

    assign prod_ext = {{(bq_pkg::ACC_WIDTH - bq_pkg::PROD_WIDTH){r_prod[bq_pkg::PROD_WIDTH-1]}},
                       r_prod};

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_coef * i_data;
        end
        case (i_acc_op)
            bq_pkg::ACC_LOAD: r_acc <= prod_ext;
            bq_pkg::ACC_ADD:  r_acc <= r_acc + prod_ext;
            default: ;
        endcase
    end

    assign o_acc = r_acc;

endmodule

// ----- hw/rtl/bq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bq_checker: port-level checks for the biquad filter
// Output handshake rules and the one-word-at-a-time input behavior.
// ---------------------------------------------------------------------------
module bq_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_out_sample,
    input logic                           o_state_flushed
);

    // a stalled result stays valid
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_sample) && $stable(o_state_flushed))
        else $error("result changed while stalled");

    // after taking a word the filter is busy on the next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on consecutive cycles");

    // after taking a word the filter is still busy at a later step of its MAC program
    a_in_busy_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##3 o_in_stall)
        else $error("input taken before the program finished");

endmodule

bind biquad_direct_form_two_filter bq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_sample    (o_out_sample),
    .o_state_flushed (o_state_flushed)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the direct form II biquad section
// Streams samples through the filter under random valid/stall gaps, predicts
// every filtered word from a bit-exact fixed-point model of the section and
// compares sample and flush flag in order. Coefficients are rewritten between
// idle phases, from the edges of the Q4.20 range to small stable poles.
// ---------------------------------------------------------------------------
module tb;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_WIDTH     = bq_pkg::COEF_WIDTH;
    localparam int DELAY_WIDTH    = bq_pkg::DELAY_WIDTH;
    localparam int CFG_IDX_WIDTH  = bq_pkg::CFG_IDX_WIDTH;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_UNITY = COEF_WIDTH'(1 << COEF_FRAC_BITS);

    localparam longint DELAY_HI  = (longint'(1) <<< (DELAY_WIDTH - 1)) - 1;
    localparam longint DELAY_LO  = -DELAY_HI - 1;
    localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

    // first register index past the coefficient bank; writes there must be dropped
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_FIRST =
        CFG_IDX_WIDTH'(int'(bq_pkg::CFG_B2) + 1);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_LAST  = '1;

    // idle styles for either side
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_ALWAYS = 1;
    localparam int IDLE_SOME   = 2;

    // coefficient styles
    localparam int COEF_FULL    = 0;
    localparam int COEF_SMALL   = 1;
    localparam int COEF_EXTREME = 2;

    localparam int  SETTLE_CYCLES = 16;       // a bit over the filter's sample period
    localparam int  LONG_HOLD     = 300;      // receiver hold-off to back up the input
    localparam int  MAX_WAIT      = 16;
    localparam int  PHASE_ITEMS   = 60;
    localparam real RUN_LIMIT_NS  = 3_000_000.0;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic                    flushed;
    } t_filtered_word;

    // DUT ports; the driven inputs are known from time zero
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]      i_cfg_index = '0;
    logic [COEF_WIDTH-1:0]         i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_in_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_out_sample;
    logic                          o_state_flushed;

    // filter mirror: coefficients and the two delays, reset to zero
    logic signed [COEF_WIDTH-1:0]  coef_a1 = '0, coef_a2 = '0;
    logic signed [COEF_WIDTH-1:0]  coef_b0 = '0, coef_b1 = '0, coef_b2 = '0;
    logic signed [DELAY_WIDTH-1:0] delay_one = '0, delay_two = '0;

    logic signed [SAMPLE_WIDTH-1:0] samples_to_send[$];
    t_filtered_word                 filtered_q[$];

    int          mismatch_count = 0;
    int          send_mode = IDLE_SOME;
    int          recv_mode = IDLE_SOME;
    int unsigned send_gap  = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    bit          hold_toggle = 1'b0;
    bit          hold_seen   = 1'b0;
    bit          in_taken    = 1'b0;
    bit          out_taken   = 1'b0;

    biquad_direct_form_two_filter #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_sample     (i_in_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_sample    (o_out_sample),
        .o_state_flushed (o_state_flushed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // half-LSB add, then arithmetic shift: ties go toward +inf
    function automatic longint round_q20(input longint acc);
        return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    endfunction

    function automatic int unsigned draw_wait(input int mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_ALWAYS: return $urandom_range(0, MAX_WAIT);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    function automatic logic [COEF_WIDTH-1:0] rand_coef(input int style);
        case (style)
            COEF_SMALL: return COEF_WIDTH'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            COEF_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return COEF_UNITY;
                    3:       return -COEF_UNITY;
                    default: return '0;
                endcase
            end
            default: return COEF_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_WIDTH'(int'($urandom_range(0, 31)) - 16);
            default: return SAMPLE_WIDTH'($urandom());
        endcase
    endfunction

    // One sample through the section; updates the mirrored delays.
    task automatic run_biquad_step(input logic signed [SAMPLE_WIDTH-1:0] x,
                                   output t_filtered_word word);
        longint inner;
        longint acc;
        logic   flushed;
        inner = longint'(x) + round_q20(longint'(coef_a1) * longint'(delay_one)
                                      + longint'(coef_a2) * longint'(delay_two));
        flushed = 1'b0;
        if (inner > DELAY_HI || inner < DELAY_LO) begin
            // w left the delay range: zero it for output and delay update
            inner   = 0;
            flushed = 1'b1;
        end
        acc = round_q20(longint'(coef_b0) * inner
                      + longint'(coef_b1) * longint'(delay_one)
                      + longint'(coef_b2) * longint'(delay_two));
        if (acc > SAMPLE_HI) acc = SAMPLE_HI;
        if (acc < SAMPLE_LO) acc = SAMPLE_LO;
        delay_two    = delay_one;
        delay_one    = DELAY_WIDTH'(inner);
        word.sample  = acc[SAMPLE_WIDTH-1:0];
        word.flushed = flushed;
    endtask

    // Register write, one clock wide; only called while the filter is idle.
    task automatic write_coef(input logic [CFG_IDX_WIDTH-1:0] idx,
                              input logic [COEF_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            bq_pkg::CFG_A1:  coef_a1 = value;
            bq_pkg::CFG_A2:  coef_a2 = value;
            bq_pkg::CFG_B0:  coef_b0 = value;
            bq_pkg::CFG_B1:  coef_b1 = value;
            bq_pkg::CFG_B2:  coef_b2 = value;
            default: ;  // spare index, dropped
        endcase
    endtask

    task automatic write_all_coefs(input logic [COEF_WIDTH-1:0] a1, input logic [COEF_WIDTH-1:0] a2,
                                   input logic [COEF_WIDTH-1:0] b0, input logic [COEF_WIDTH-1:0] b1,
                                   input logic [COEF_WIDTH-1:0] b2);
        write_coef(bq_pkg::CFG_A1, a1);
        write_coef(bq_pkg::CFG_A2, a2);
        write_coef(bq_pkg::CFG_B0, b0);
        write_coef(bq_pkg::CFG_B1, b1);
        write_coef(bq_pkg::CFG_B2, b2);
    endtask

    // Waits until every queued sample is out and every word is back,
    // then lets the sequencer run out its program. Checked at the rising
    // edge, where the driven valid has settled.
    task automatic drain();
        while (samples_to_send.size() != 0 || i_in_valid || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n_items, input bit long_hold,
                                input int s_mode, input int r_mode);
        int fb_style;
        int ff_style;
        fb_style = ($urandom_range(0, 3) == 3) ? COEF_SMALL
                                               : int'($urandom_range(COEF_FULL, COEF_EXTREME));
        ff_style = int'($urandom_range(COEF_FULL, COEF_EXTREME));
        write_all_coefs(rand_coef(fb_style), rand_coef(fb_style), rand_coef(ff_style),
                        rand_coef(ff_style), rand_coef(ff_style));
        if ($urandom_range(0, 3) == 0)
            write_coef(CFG_IDX_WIDTH'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                       COEF_WIDTH'($urandom()));
        send_mode = s_mode;
        recv_mode = r_mode;
        if (long_hold)
            hold_toggle = ~hold_toggle;
        repeat (n_items) samples_to_send.push_back(rand_sample());
        drain();
    endtask

    // -----------------------------------------------------------------------
    // Sample driver: next word goes out at the falling edge after the last
    // one was taken, after its own random gap.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap   = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (samples_to_send.size() > 0) begin
                i_in_sample <= samples_to_send.pop_front();
                i_in_valid  <= 1'b1;
                send_gap    = draw_wait(send_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result receiver: random stall after each taken word, plus a long
    // hold-off on request so the filter backs up into its input.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
        end
        if (out_taken)
            recv_wait = draw_wait(recv_mode);
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (recv_wait > 0) begin
            recv_wait   = recv_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: predict on every taken sample, check every taken result
    // against the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_filtered_word predicted;
        t_filtered_word oldest;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_in_valid && !o_in_stall;
            out_taken <= o_out_valid && !i_out_stall;
            if (i_in_valid && !o_in_stall) begin
                run_biquad_step(i_in_sample, predicted);
                filtered_q.push_back(predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, got sample %0d flushed %0b",
                             $realtime, o_out_sample, o_state_flushed);
                end else begin
                    oldest = filtered_q.pop_front();
                    if (oldest.sample !== o_out_sample) begin
                        mismatch_count++;
                        $display("%0t: out_sample expected %0d got %0d", $realtime,
                                 $signed(oldest.sample), o_out_sample);
                    end
                    if (oldest.flushed !== o_state_flushed) begin
                        mismatch_count++;
                        $display("%0t: state_flushed expected %0b got %0b", $realtime,
                                 oldest.flushed, o_state_flushed);
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus: reset, directed corners, then random phases.
    // -----------------------------------------------------------------------
    initial begin : stimulus
        int k;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset coefficients are all zero: every word must come back as zero
        send_mode = IDLE_SOME;
        recv_mode = IDLE_SOME;
        samples_to_send.push_back(SAMPLE_MAX);
        samples_to_send.push_back(SAMPLE_MIN);
        samples_to_send.push_back('0);
        samples_to_send.push_back(SAMPLE_WIDTH'(-1));
        drain();

        // spare indexes must not land anywhere; with b0 = 1.0 it is a wire
        for (k = int'(CFG_SPARE_FIRST); k <= int'(CFG_SPARE_LAST); k++)
            write_coef(CFG_IDX_WIDTH'(k), COEF_WIDTH'($urandom()));
        write_coef(bq_pkg::CFG_B0, COEF_UNITY);
        samples_to_send.push_back(SAMPLE_MAX);
        samples_to_send.push_back(SAMPLE_MIN);
        samples_to_send.push_back(SAMPLE_WIDTH'(1));
        samples_to_send.push_back(SAMPLE_WIDTH'(-1));
        samples_to_send.push_back(SAMPLE_WIDTH'(24'h555555));
        samples_to_send.push_back(SAMPLE_WIDTH'(24'hAAAAAA));
        drain();

        // b0 = 0.5: odd samples land on a half LSB, ties go up
        write_coef(bq_pkg::CFG_B0, COEF_UNITY >>> 1);
        samples_to_send.push_back(SAMPLE_WIDTH'(1));
        samples_to_send.push_back(SAMPLE_WIDTH'(-1));
        samples_to_send.push_back(SAMPLE_WIDTH'(3));
        samples_to_send.push_back(SAMPLE_WIDTH'(-3));
        drain();

        // largest gain: output saturates both ways
        write_coef(bq_pkg::CFG_B0, COEF_MAX);
        samples_to_send.push_back(SAMPLE_MAX);
        samples_to_send.push_back(SAMPLE_MIN);
        drain();

        // runaway feedback: w grows past the delay range and gets flushed
        write_all_coefs(COEF_MAX, COEF_MAX, COEF_UNITY, COEF_MIN, COEF_MIN);
        repeat (5) samples_to_send.push_back(SAMPLE_MAX);
        drain();

        write_all_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        repeat (4) samples_to_send.push_back(SAMPLE_MIN);
        drain();

        // back to back with no idling, then a long receiver hold-off
        random_phase(PHASE_ITEMS, 1'b0, IDLE_NONE, IDLE_NONE);
        random_phase(40, 1'b1, IDLE_NONE, IDLE_SOME);
        for (k = 0; k < 9; k++)
            random_phase(PHASE_ITEMS, 1'b0, $urandom_range(IDLE_NONE, IDLE_SOME),
                         $urandom_range(IDLE_NONE, IDLE_SOME));

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (filtered_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d words still expected at end of run", $realtime, filtered_q.size());
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached", $realtime);
        $display("Regression FAIL");
        $finish;
    end

endmodule
